@@ rtl/bmle_pkg.sv @@
// ----------------------------------------------------------------------------
// bmle_pkg
// shared constants, codes and the command type of the bank member list engine
// ----------------------------------------------------------------------------
package bmle_pkg;

    localparam int BANKS_DEF = 256;
    localparam int SLOTS_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int OP_W = 3;
    localparam int BANK_W = 8;
    localparam int POS_W = 6;
    localparam int CH_W = 12;
    localparam int MEM_W = 13;
    localparam int VAL_W = 13;
    localparam int ST_W = 2;
    localparam int BIU_W = 9;
    localparam int IN_W = 48;
    localparam int OUT_W = 16;
    localparam int CFG_W = 12;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_COMPACT = 3'd2;
    localparam logic [OP_W-1:0] OP_READ = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd4;
    localparam logic [OP_W-1:0] OP_OPEN = 3'd5;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
    localparam logic [ST_W-1:0] ST_VALID = 2'd3;

    localparam logic [0:0] REG_BANKS_IN_USE = 1'd0;
    localparam logic [0:0] REG_CHANNELS_IN_USE = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              err;
        logic [BANK_W-1:0] bank;
        logic [POS_W-1:0]  pos;
        logic [MEM_W-1:0]  d1;
        logic [MEM_W-1:0]  m1;
    } cmd_t;

endpackage

@@ rtl/bmle_front.sv @@
// ----------------------------------------------------------------------------
// bmle_front
// accepts items, range checks them and hands commands to the queue
// ----------------------------------------------------------------------------
module bmle_front
    import bmle_pkg::*;
#(
    parameter int BANKS = BANKS_DEF,
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // op, bank, position, channel, moved_channel
    input  logic [BIU_W-1:0]  banks_in_use,
    input  logic [CH_W-1:0]   channels_in_use,
    input  logic              q_full,
    input  logic              clearing,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic [OP_W-1:0]   op;
    logic [BANK_W-1:0] bank;
    logic [POS_W-1:0]  pos;
    logic [CH_W-1:0]   ch;
    logic [CH_W-1:0]   mv;
    logic              bank_ok;
    logic              pos_ok;
    logic              err;

    assign op = s_tdata[2:0];
    assign bank = s_tdata[10:3];
    assign pos = s_tdata[16:11];
    assign ch = s_tdata[28:17];
    assign mv = s_tdata[40:29];

    assign bank_ok = ({1'b0, bank} < banks_in_use) && (32'(bank) < BANKS);
    assign pos_ok = 32'(pos) < SLOTS;

    always_comb
    begin
        err = 1'b0;
        case (op)
            OP_COMPACT:
            begin
                err = 1'b0;
            end
            OP_OPEN, OP_CLOSE, OP_COUNT:
            begin
                err = !bank_ok;
            end
            OP_INSERT:
            begin
                err = !bank_ok || !pos_ok || (ch >= channels_in_use);
            end
            OP_DELETE, OP_READ:
            begin
                err = !bank_ok || !pos_ok;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    assign s_tready = !q_full && !clearing;
    assign q_push = s_tvalid && s_tready;

    always_comb
    begin
        q_cmd.op = op;
        q_cmd.err = err;
        q_cmd.bank = bank;
        q_cmd.pos = pos;
        q_cmd.d1 = {1'b0, ch} + 13'd1;
        q_cmd.m1 = {1'b0, mv} + 13'd1;
    end

endmodule

@@ rtl/bmle_fifo.sv @@
// ----------------------------------------------------------------------------
// bmle_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module bmle_fifo
    import bmle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          buf_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_reg;
    logic [PW-1:0] rp_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign full = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout = buf_reg[rp_reg];

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= din;
        end
    end

endmodule

@@ rtl/bmle_back.sv @@
// ----------------------------------------------------------------------------
// bmle_back
// slot sequencer: walks the member memory one slot a cycle per command
// ----------------------------------------------------------------------------
module bmle_back
    import bmle_pkg::*;
#(
    parameter int BANKS = BANKS_DEF,
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [BIU_W-1:0]  banks_in_use,
    output logic              clearing,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // status, value
);

    localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int SW = $clog2(SLOTS);
    localparam int IW = SW + 1;
    localparam int AW = BW + SW;
    localparam int LW = $clog2(BANKS + 1);
    localparam int MDEPTH = 1 << AW;
    localparam logic [IW-1:0] SL = IW'(SLOTS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_SHUP = 4'd3;
    localparam logic [3:0] S_PUT = 4'd4;
    localparam logic [3:0] S_SHDN = 4'd5;
    localparam logic [3:0] S_ZERO = 4'd6;
    localparam logic [3:0] S_COUNT = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;
    localparam logic [3:0] S_READW = 4'd9;
    localparam logic [3:0] S_CBANK = 4'd10;
    localparam logic [3:0] S_CPACK = 4'd11;

    logic [MEM_W-1:0] mem [MDEPTH];
    logic [MEM_W-1:0] rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;

    logic [3:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [BW-1:0]    bank_reg, bank_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    tgt_reg, tgt_next;
    logic [IW-1:0]    wtgt_reg, wtgt_next;
    logic [IW-1:0]    n_reg, n_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]    b_reg, b_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             rv_reg, rv_next;
    logic             found_reg, found_next;
    logic             stop_reg, stop_next;
    logic [BANKS-1:0] valid_reg, valid_next;
    logic             ov_reg, ov_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [VAL_W-1:0] val_reg, val_next;

    logic [LW-1:0]    lim;
    logic [BW-1:0]    cbank;
    logic [IW-1:0]    pos_i;

    assign lim = (32'(banks_in_use) < BANKS) ? LW'(banks_in_use) : LW'(BANKS);
    assign cbank = BW'(cmd.bank);
    assign pos_i = IW'(cmd_reg.pos);

    assign clearing = (state_reg == S_CLEAR);
    assign m_tvalid = ov_reg;
    assign m_tdata = {1'b0, val_reg, st_reg};

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        bank_next = bank_reg;
        idx_next = idx_reg;
        tgt_next = tgt_reg;
        wtgt_next = wtgt_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        b_next = b_reg;
        clr_next = clr_reg;
        rv_next = 1'b0;
        found_next = found_reg;
        stop_next = stop_reg;
        valid_next = valid_reg;
        ov_next = ov_reg && !m_tready;
        st_next = st_reg;
        val_next = val_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty && !ov_reg)
                begin
                    q_pop = 1'b1;
                    cmd_next = cmd;
                    bank_next = cbank;
                    idx_next = '0;
                    cnt_next = '0;
                    found_next = 1'b0;
                    stop_next = 1'b0;
                    tgt_next = IW'(cmd.pos);
                    if (cmd.err)
                    begin
                        ov_next = 1'b1;
                        st_next = ST_RANGE;
                        val_next = '0;
                    end
                    else
                    begin
                        case (cmd.op)
                            OP_COMPACT:
                            begin
                                b_next = '0;
                                state_next = S_CBANK;
                            end
                            OP_OPEN:
                            begin
                                ov_next = 1'b1;
                                val_next = '0;
                                if (valid_reg[cbank])
                                begin
                                    st_next = ST_VALID;
                                end
                                else
                                begin
                                    st_next = ST_OK;
                                    valid_next[cbank] = 1'b1;
                                end
                            end
                            OP_CLOSE:
                            begin
                                valid_next[cbank] = 1'b0;
                                state_next = S_ZERO;
                            end
                            OP_COUNT, OP_INSERT, OP_DELETE, OP_READ:
                            begin
                                if (!valid_reg[cbank])
                                begin
                                    ov_next = 1'b1;
                                    st_next = ST_INVALID;
                                    val_next = '0;
                                end
                                else if (cmd.op == OP_COUNT)
                                begin
                                    state_next = S_COUNT;
                                end
                                else if (cmd.op == OP_INSERT)
                                begin
                                    state_next = S_SCAN;
                                end
                                else if (cmd.op == OP_DELETE)
                                begin
                                    state_next = S_SHDN;
                                end
                                else
                                begin
                                    state_next = S_READ;
                                end
                            end
                            default:
                            begin
                                ov_next = 1'b1;
                                st_next = ST_RANGE;
                                val_next = '0;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < SL)
                begin
                    mem_raddr = {bank_reg, idx_reg[SW-1:0]};
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rv_reg && (rdata_reg == cmd_reg.d1))
                begin
                    found_next = 1'b1;
                end
                if ((idx_reg == SL) && !rv_reg)
                begin
                    if (found_reg)
                    begin
                        ov_next = 1'b1;
                        st_next = ST_OK;
                        val_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tgt_next = SL - 1'b1;
                        state_next = S_SHUP;
                    end
                end
            end
            S_SHUP:
            begin
                if (tgt_reg > pos_i)
                begin
                    mem_raddr = {bank_reg, SW'(tgt_reg - 1'b1)};
                    rv_next = 1'b1;
                    wtgt_next = tgt_reg;
                    tgt_next = tgt_reg - 1'b1;
                end
                if (rv_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = {bank_reg, wtgt_reg[SW-1:0]};
                    mem_wdata = rdata_reg;
                end
                if (!(tgt_reg > pos_i) && !rv_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_waddr = {bank_reg, pos_i[SW-1:0]};
                mem_wdata = cmd_reg.d1;
                ov_next = 1'b1;
                st_next = ST_OK;
                val_next = '0;
                state_next = S_IDLE;
            end
            S_SHDN:
            begin
                if ((tgt_reg + 1'b1) < SL)
                begin
                    mem_raddr = {bank_reg, SW'(tgt_reg + 1'b1)};
                    rv_next = 1'b1;
                    wtgt_next = tgt_reg;
                    tgt_next = tgt_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = {bank_reg, wtgt_reg[SW-1:0]};
                    mem_wdata = rdata_reg;
                end
                if (!((tgt_reg + 1'b1) < SL) && !rv_reg)
                begin
                    idx_next = SL - 1'b1;
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (idx_reg < SL)
                begin
                    mem_we = 1'b1;
                    mem_waddr = {bank_reg, idx_reg[SW-1:0]};
                    idx_next = idx_reg + 1'b1;
                end
                else if (cmd_reg.op == OP_COMPACT)
                begin
                    b_next = b_reg + 1'b1;
                    state_next = S_CBANK;
                end
                else
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    val_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_COUNT:
            begin
                if (idx_reg < SL)
                begin
                    mem_raddr = {bank_reg, idx_reg[SW-1:0]};
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if ((rdata_reg != '0) && !stop_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
                if ((idx_reg == SL) && !rv_reg)
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    val_next = VAL_W'(cnt_reg);
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                mem_raddr = {bank_reg, pos_i[SW-1:0]};
                state_next = S_READW;
            end
            S_READW:
            begin
                ov_next = 1'b1;
                st_next = ST_OK;
                val_next = rdata_reg - 1'b1;
                state_next = S_IDLE;
            end
            S_CBANK:
            begin
                if (b_reg == lim)
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    val_next = '0;
                    state_next = S_IDLE;
                end
                else if (valid_reg[BW'(b_reg)])
                begin
                    bank_next = BW'(b_reg);
                    idx_next = '0;
                    n_next = '0;
                    state_next = S_CPACK;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
            end
            S_CPACK:
            begin
                if (idx_reg < SL)
                begin
                    mem_raddr = {bank_reg, idx_reg[SW-1:0]};
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rv_reg && (rdata_reg != '0) && (rdata_reg != cmd_reg.d1))
                begin
                    mem_we = 1'b1;
                    mem_waddr = {bank_reg, n_reg[SW-1:0]};
                    mem_wdata = (rdata_reg == cmd_reg.m1) ? cmd_reg.d1 : rdata_reg;
                    n_next = n_reg + 1'b1;
                end
                if ((idx_reg == SL) && !rv_reg)
                begin
                    idx_next = n_reg;
                    state_next = S_ZERO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            rv_reg <= 1'b0;
            valid_reg <= '0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            tgt_reg <= '0;
            wtgt_reg <= '0;
            n_reg <= '0;
            cnt_reg <= '0;
            b_reg <= '0;
            found_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            rv_reg <= rv_next;
            valid_reg <= valid_next;
            ov_reg <= ov_next;
            idx_reg <= idx_next;
            tgt_reg <= tgt_next;
            wtgt_reg <= wtgt_next;
            n_reg <= n_next;
            cnt_reg <= cnt_next;
            b_reg <= b_next;
            found_reg <= found_next;
            stop_reg <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        bank_reg <= bank_next;
        st_reg <= st_next;
        val_reg <= val_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

@@ rtl/bank_member_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// bank_member_list_engine_core
// bank store with ordered member slots: open, close, insert, delete, compact, read, count
// ----------------------------------------------------------------------------
// items come in on the s_ channel, one result item per command leaves on m_.
// register writes use cfg_valid/cfg_ready with cfg_index and cfg_data; they
// are taken at any time but meant only while the block is idle.
// a front stage range checks each item and puts it in a two entry queue; the
// back walks the member memory one slot per cycle through one read and one
// write port. open and error results are answered from idle; read passes a
// read state and a wait state; count and close walk every slot of the bank;
// delete shifts the slots above the position down, then clears the last slot;
// insert scans the bank and, if the channel is absent, shifts the slots up and
// puts it; compact packs each open bank in use and then clears its tail.
// after reset the memory is cleared, all 2^(clog2(BANKS) + clog2(SLOTS))
// words (16384 at the defaults), while s_tready stays low.
// a stalled receiver holds the result in the output register; the queue keeps
// taking items until it is full.
// ----------------------------------------------------------------------------
module bank_member_list_engine_core
    import bmle_pkg::*;
#(
    parameter int BANKS = BANKS_DEF,
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // op, bank, position, channel, moved_channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // status, value
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [BIU_W-1:0] biu_reg;
    logic [CH_W-1:0]  ciu_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             clearing;
    cmd_t             q_in;
    cmd_t             q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg <= 9'd250;
            ciu_reg <= 12'd3000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BANKS_IN_USE:    biu_reg <= cfg_data[BIU_W-1:0];
                REG_CHANNELS_IN_USE: ciu_reg <= cfg_data;
                default:             ciu_reg <= ciu_reg;
            endcase
        end
    end

    bmle_front #(.BANKS(BANKS), .SLOTS(SLOTS)) u_front
    (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .banks_in_use    (biu_reg),
        .channels_in_use (ciu_reg),
        .q_full          (q_full),
        .clearing        (clearing),
        .q_push          (q_push),
        .q_cmd           (q_in)
    );

    bmle_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    bmle_back #(.BANKS(BANKS), .SLOTS(SLOTS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .banks_in_use (biu_reg),
        .clearing     (clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

@@ rtl/bmle_checker.sv @@
// ----------------------------------------------------------------------------
// bmle_checker
// port level checks of the bank member list engine, bound to the top level
// ----------------------------------------------------------------------------
module bmle_checker
    import bmle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[14:2] == '0))
        else $error("error result carries a value");

    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input taken during the clearing pass");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[15])
        else $error("padding bit set");

endmodule

bind bank_member_list_engine_core bmle_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/bank_member_list_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// bank_member_list_engine_core_tb
// checks the bank member list engine against a cycle-free model of its
// banks and slots; directed items first, then random commands with bursty
// input, a stalling receiver and several register settings
// ----------------------------------------------------------------------------
module bank_member_list_engine_core_tb;
    import bmle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class bank_list_predictor;
        logic [MEM_W-1:0] slots [BANKS_DEF][SLOTS_DEF];
        bit               open_flag [BANKS_DEF];
        int unsigned      banks_in_use;
        int unsigned      channels_in_use;
        logic [ST_W-1:0]  expected_status [$];
        logic [VAL_W-1:0] expected_value [$];
        int               mismatches;

        function new();
            foreach (slots[b, s]) slots[b][s] = '0;
            foreach (open_flag[b]) open_flag[b] = 1'b0;
            banks_in_use = 250;
            channels_in_use = 3000;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [BANK_W-1:0] b,
                                   logic [POS_W-1:0] p, logic [CH_W-1:0] ch,
                                   logic [CH_W-1:0] mv);
            logic [ST_W-1:0]  st;
            logic [VAL_W-1:0] val;
            logic [MEM_W-1:0] packed_s [SLOTS_DEF];
            logic [MEM_W-1:0] m;
            logic [MEM_W-1:0] del1;
            logic [MEM_W-1:0] mov1;
            bit               present;
            int               n;
            st = ST_OK;
            val = '0;
            del1 = {1'b0, ch} + 13'd1;
            mov1 = {1'b0, mv} + 13'd1;
            if (op == OP_COMPACT)
            begin
                for (int i = 0; i < BANKS_DEF && i < banks_in_use; i++)
                begin
                    if (open_flag[i])
                    begin
                        n = 0;
                        foreach (packed_s[k]) packed_s[k] = '0;
                        for (int s = 0; s < SLOTS_DEF; s++)
                        begin
                            m = slots[i][s];
                            if (m != '0 && m != del1)
                            begin
                                packed_s[n] = (m == mov1) ? del1 : m;
                                n++;
                            end
                        end
                        foreach (packed_s[k]) slots[i][k] = packed_s[k];
                    end
                end
            end
            else if (32'(b) >= banks_in_use)
            begin
                st = ST_RANGE;
            end
            else
            begin
                case (op)
                    OP_OPEN:
                        if (open_flag[b]) st = ST_VALID;
                        else
                        begin
                            open_flag[b] = 1'b1;
                            for (int s = 16; s < SLOTS_DEF; s++) slots[b][s] = '0;
                        end
                    OP_CLOSE:
                    begin
                        open_flag[b] = 1'b0;
                        for (int s = 0; s < SLOTS_DEF; s++) slots[b][s] = '0;
                    end
                    OP_COUNT:
                        if (!open_flag[b]) st = ST_INVALID;
                        else
                            while (val < SLOTS_DEF && slots[b][val] != '0) val++;
                    OP_INSERT:
                        if (32'(ch) >= channels_in_use) st = ST_RANGE;
                        else if (!open_flag[b]) st = ST_INVALID;
                        else
                        begin
                            present = 1'b0;
                            for (int s = 0; s < SLOTS_DEF; s++)
                                if (slots[b][s] == del1) present = 1'b1;
                            if (!present)
                            begin
                                for (int s = SLOTS_DEF - 1; s > int'(p); s--)
                                    slots[b][s] = slots[b][s-1];
                                slots[b][p] = del1;
                            end
                        end
                    OP_DELETE:
                        if (!open_flag[b]) st = ST_INVALID;
                        else
                        begin
                            for (int s = int'(p); s + 1 < SLOTS_DEF; s++)
                                slots[b][s] = slots[b][s+1];
                            slots[b][SLOTS_DEF-1] = '0;
                        end
                    OP_READ:
                        if (!open_flag[b]) st = ST_INVALID;
                        else val = slots[b][p] - 13'd1;
                    default:
                        st = ST_RANGE;
                endcase
            end
            expected_status.push_back(st);
            expected_value.push_back(val);
        endfunction

        function void check_answer(logic [ST_W-1:0] st, logic [VAL_W-1:0] val);
            logic [ST_W-1:0]  exp_st;
            logic [VAL_W-1:0] exp_val;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d value %0d", st, val);
                return;
            end
            exp_st = expected_status.pop_front();
            exp_val = expected_value.pop_front();
            if (st !== exp_st || val !== exp_val)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
                             exp_st, st, $signed(exp_val), $signed(val));
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    bank_list_predictor model = new();
    int                accepted_items = 0;
    int unsigned       cycles = 0;

    bank_member_list_engine_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: changing stall modes plus one long hold-off
    int  rx_mode = 0;
    int  hold_left = 0;
    bit  held_long = 1'b0;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_answer(m_tdata[1:0], m_tdata[14:2]);
        if (cycles % 300 == 0)
            rx_mode = int'($urandom_range(0, 3));
        if (!held_long && accepted_items >= 40)
        begin
            held_long = 1'b1;
            hold_left = 800;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 0);
                2: m_tready <= (cycles % 8 < 2);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [BANK_W-1:0] b,
                             logic [POS_W-1:0] p, logic [CH_W-1:0] ch,
                             logic [CH_W-1:0] mv);
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, mv, ch, p, b, op};
        do @(posedge clk); while (!s_tready);
        model.note_command(op, b, p, ch, mv);
        accepted_items++;
    endtask

    task automatic pause_sender(int gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (model.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BANKS_IN_USE) model.banks_in_use = 32'(data[BIU_W-1:0]);
        else model.channels_in_use = 32'(data);
        @(posedge clk);
    endtask

    task automatic random_item();
        logic [OP_W-1:0]   op;
        logic [BANK_W-1:0] b;
        logic [POS_W-1:0]  p;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   mv;
        int                r;
        r = int'($urandom_range(0, 99));
        if (r < 32) op = OP_INSERT;
        else if (r < 46) op = OP_DELETE;
        else if (r < 48) op = OP_COMPACT;
        else if (r < 64) op = OP_READ;
        else if (r < 76) op = OP_COUNT;
        else if (r < 90) op = OP_OPEN;
        else if (r < 97) op = OP_CLOSE;
        else op = OP_RESERVED;
        b = ($urandom_range(0, 9) != 0) ? BANK_W'($urandom_range(0, 11))
                                        : BANK_W'($urandom_range(0, 255));
        p = ($urandom_range(0, 2) != 0) ? POS_W'($urandom_range(0, 20))
                                        : POS_W'($urandom_range(0, 63));
        ch = ($urandom_range(0, 4) != 0) ? CH_W'($urandom_range(0, 24))
                                         : CH_W'($urandom_range(0, 4095));
        mv = ($urandom_range(0, 3) != 0) ? CH_W'($urandom_range(0, 24))
                                         : CH_W'($urandom_range(0, 4095));
        send_item(op, b, p, ch, mv);
    endtask

    task automatic random_phase(int count);
        int done;
        int burst;
        done = 0;
        while (done < count)
        begin
            burst = int'($urandom_range(1, 24));
            for (int k = 0; k < burst && done < count; k++)
            begin
                random_item();
                done++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender(int'($urandom_range(1, 12)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_item(OP_OPEN, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_OPEN, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_INSERT, 8'd0, 6'd0, 12'd2999, 12'd0);
        send_item(OP_INSERT, 8'd0, 6'd0, 12'd3000, 12'd0);
        send_item(OP_INSERT, 8'd0, 6'd63, 12'd0, 12'd0);
        send_item(OP_INSERT, 8'd0, 6'd1, 12'd0, 12'd0);
        send_item(OP_INSERT, 8'd0, 6'd1, 12'd7, 12'd0);
        send_item(OP_READ, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_READ, 8'd0, 6'd63, 12'd0, 12'd0);
        send_item(OP_COUNT, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_DELETE, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_COUNT, 8'd5, 6'd0, 12'd0, 12'd0);
        send_item(OP_READ, 8'd5, 6'd0, 12'd0, 12'd0);
        send_item(OP_DELETE, 8'd5, 6'd3, 12'd0, 12'd0);
        send_item(OP_INSERT, 8'd5, 6'd3, 12'd1, 12'd0);
        send_item(OP_OPEN, 8'd255, 6'd0, 12'd0, 12'd0);
        send_item(OP_RESERVED, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_OPEN, 8'd249, 6'd0, 12'd0, 12'd0);
        send_item(OP_INSERT, 8'd249, 6'd0, 12'd5, 12'd0);
        send_item(OP_COMPACT, 8'd0, 6'd0, 12'd7, 12'd2999);
        send_item(OP_READ, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_CLOSE, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_OPEN, 8'd0, 6'd0, 12'd0, 12'd0);
        send_item(OP_COUNT, 8'd0, 6'd0, 12'd0, 12'd0);
        drain();

        random_phase(150);
        drain();
        write_reg(REG_BANKS_IN_USE, 12'd256);
        write_reg(REG_CHANNELS_IN_USE, 12'd4095);
        random_phase(170);
        drain();
        write_reg(REG_BANKS_IN_USE, 12'd1);
        write_reg(REG_CHANNELS_IN_USE, 12'd1);
        random_phase(80);
        drain();
        write_reg(REG_BANKS_IN_USE, 12'd7);
        write_reg(REG_CHANNELS_IN_USE, 12'd12);
        random_phase(150);
        drain();
        write_reg(REG_BANKS_IN_USE, 12'd256);
        write_reg(REG_CHANNELS_IN_USE, 12'd4095);
        random_phase(150);
        drain();
        repeat (200) @(posedge clk);

        if (model.mismatches == 0 && model.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
